/* rtl/core/ovn_pkg.sv */
// Shared types, widths and constants for the octave value noise unit.
// Also builds the cosine-weight ROM contents at elaboration time.
// No dependencies.
package ovn_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int COS_TABLE_BITS = 10;
	localparam int COS_DEPTH      = 1 << COS_TABLE_BITS;
	localparam int W_W            = FRAC_BITS + 1;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int OCT_LIMIT       = 16;
	localparam int SHIFT_PAD       = OCT_LIMIT - 1;

	localparam int COORD_W = 16;
	localparam int X_W     = COORD_W + 1;
	localparam int FREQ_W  = 20;
	localparam int XB_W    = X_W + FREQ_W;
	localparam int AMP_W   = 24;
	localparam int PERS_W  = 17;
	localparam int CNT_W   = 5;
	localparam int OCNT_W  = 4;
	localparam int TOT_W   = 48;
	localparam int OUT_W   = 32;
	localparam int CFG_W   = 24;
	localparam int ADDR_W  = 3;

	localparam logic [AMP_W-1:0] AMP_MAX = '1;

	// Configuration register indexes.
	localparam logic [ADDR_W-1:0] REG_COORD_OFFSET   = 3'd0;
	localparam logic [ADDR_W-1:0] REG_OCTAVE_COUNT   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_BASE_FREQUENCY = 3'd2;
	localparam logic [ADDR_W-1:0] REG_BASE_AMPLITUDE = 3'd3;
	localparam logic [ADDR_W-1:0] REG_PERSISTENCE    = 3'd4;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [W_W-1:0] cos_rom_t [COS_DEPTH];

	// Data handed from one octave cell to the next.
	typedef struct packed {
		logic [XB_W-1:0]         xb;
		logic [XB_W-1:0]         yb;
		logic [CNT_W-1:0]        count;
		logic [AMP_W-1:0]        amp;
		logic signed [TOT_W-1:0] total;
	} ovn_pass_t;

	// sin^2 over a quarter period, Taylor series in Q.30, rounded to Q.FRAC_BITS.
	function automatic cos_rom_t cos_rom_init();
		cos_rom_t rom;
		longint unsigned x, x2, term, s, w;
		longint sum;
		for (int k = 0; k < COS_DEPTH; k++) begin
			x = (HALF_PI_Q30 * longint'(k)) >> COS_TABLE_BITS;
			x2 = (x * x) >> 30;
			sum = longint'(x);
			term = ((x * x2) >> 30) / 6;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 156;
			sum = sum + longint'(term);
			if (sum < 0) sum = 0;
			if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
			s = longint'(sum);
			w = (s * s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
			if (w > (64'd1 << FRAC_BITS)) w = 64'd1 << FRAC_BITS;
			rom[k] = W_W'(w);
		end
		return rom;
	endfunction

endpackage

/* rtl/core/ovn_hash.sv */
// Pipelined 32-bit lattice hash, five register stages, result in [-1,1] as Q.30.
// Depends on nothing but the clock enable from its octave cell.
module ovn_hash (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        x,
	input  logic [31:0]        y,
	output logic signed [31:0] value
);

	logic [31:0] n;
	logic [31:0] n_s1, n_s2, n_s3;
	logic [31:0] sq_s2, t_s3, m_s4, mm;

	always_comb begin
		n = x + y * 32'd57;
		n = (n << 13) ^ n;
	end

	assign mm = m_s4 + 32'd1376312589;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= n;
			sq_s2 <= n_s1 * n_s1;
			n_s2  <= n_s1;
			t_s3  <= sq_s2 * 32'd15731 + 32'd789221;
			n_s3  <= n_s2;
			m_s4  <= n_s3 * t_s3;
			value <= $signed(32'h4000_0000) - $signed({1'b0, mm[30:0]});
		end
	end

endmodule

/* rtl/core/ovn_cos_rom.sv */
// Cosine-weight ROM with two registered read ports.
// Contents come from ovn_pkg::cos_rom_init.
module ovn_cos_rom (
	input  logic                              clk,
	input  logic                              en,
	input  logic [ovn_pkg::COS_TABLE_BITS-1:0] idx_a,
	input  logic [ovn_pkg::COS_TABLE_BITS-1:0] idx_b,
	output logic [ovn_pkg::W_W-1:0]           w_a,
	output logic [ovn_pkg::W_W-1:0]           w_b
);

	localparam ovn_pkg::cos_rom_t ROM = ovn_pkg::cos_rom_init();

	always_ff @(posedge clk) begin
		if (en) begin
			w_a <= ROM[idx_a];
			w_b <= ROM[idx_b];
		end
	end

endmodule

/* rtl/core/ovn_cell.sv */
// One octave of the noise sum: a 17-stage pipeline that adds its weighted
// octave to the running total. Uses ovn_pkg, ovn_hash and ovn_cos_rom.
module ovn_cell #(
	parameter int OCTAVE = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  ovn_pkg::ovn_pass_t            pass_in,
	input  logic [ovn_pkg::PERS_W-1:0]    persistence,
	output logic                          out_vld,
	output ovn_pkg::ovn_pass_t            pass_out
);

	localparam int NSTG = 17;
	localparam int FB   = ovn_pkg::FRAC_BITS;
	localparam int CTB  = ovn_pkg::COS_TABLE_BITS;
	localparam int SH_W = ovn_pkg::XB_W + ovn_pkg::SHIFT_PAD;
	localparam int AP_W = ovn_pkg::AMP_W + ovn_pkg::PERS_W;
	localparam int AR_W = AP_W - FB + 1;
	localparam int SM_W = 37;
	localparam int BL_W = 38;
	localparam int D_W  = BL_W + 1;
	localparam int P_W  = D_W + ovn_pkg::W_W + 1;
	localparam int OV_W = 20;
	localparam int C_W  = OV_W + ovn_pkg::AMP_W + 1;

	localparam logic signed [P_W-1:0]  P_HALF  = P_W'(1) <<< (FB - 1);
	localparam logic signed [BL_W-1:0] R_HALF  = BL_W'(1) <<< (33 - FB);
	localparam logic [AP_W-1:0]        A_HALF  = AP_W'(1) << (FB - 1);

	typedef struct packed {
		ovn_pkg::ovn_pass_t        pass;
		logic [ovn_pkg::AMP_W-1:0] amp_next;
		logic [CTB-1:0]            cix;
		logic [CTB-1:0]            ciy;
	} cell_carry_t;

	logic        vld_s [1:NSTG];
	cell_carry_t carry_s [1:NSTG];
	cell_carry_t carry_2, carry_last;

	logic [SH_W-1:0] shx, shy;
	logic [31:0]     ix_s1, iy_s1;
	logic [AP_W-1:0] amp_prod_s1;
	logic [AR_W-1:0] amp_rnd;
	logic [ovn_pkg::AMP_W-1:0] amp_nxt;

	logic signed [31:0]      lat [4][4];
	logic signed [33:0]      csum_s7 [4];
	logic signed [33:0]      ssum_s7 [4];
	logic signed [31:0]      ctr_s7 [4];
	logic signed [SM_W-1:0]  sm_s8 [4];
	logic signed [D_W-1:0]   d12_s9, d34_s9, d_s12;
	logic signed [SM_W-1:0]  v1_s9, v3_s9, v1_s10, v3_s10;
	logic signed [P_W-1:0]   p12_s10, p34_s10, p_s13;
	logic signed [BL_W-1:0]  a_s11, b_s11, a_s12, a_s13, r_s14;
	logic signed [P_W-1:0]   p12_r, p34_r, p_r;
	logic signed [BL_W-1:0]  r_r;
	logic signed [OV_W-1:0]  ov_s15;
	logic signed [C_W-1:0]   contrib_s16;
	logic [ovn_pkg::W_W-1:0] wx_s9, wy_s12;
	logic                    active;

	function automatic logic CNT_W_CMP(input logic [ovn_pkg::CNT_W-1:0] cnt);
		return ovn_pkg::CNT_W'(OCTAVE) < cnt;
	endfunction

	assign shx = {{ovn_pkg::SHIFT_PAD{1'b0}}, pass_in.xb} << OCTAVE;
	assign shy = {{ovn_pkg::SHIFT_PAD{1'b0}}, pass_in.yb} << OCTAVE;

	assign amp_rnd = AR_W'((amp_prod_s1 + A_HALF) >> FB);
	assign amp_nxt = (amp_rnd > AR_W'(ovn_pkg::AMP_MAX)) ? ovn_pkg::AMP_MAX :
		ovn_pkg::AMP_W'(amp_rnd);

	// 4x4 lattice values around the cell, from (ix-1, iy-1) to (ix+2, iy+2).
	for (genvar a = 0; a < 4; a++) begin : g_hx
		for (genvar b = 0; b < 4; b++) begin : g_hy
			ovn_hash u_hash (
				.clk   (clk),
				.en    (en),
				.x     (ix_s1 + 32'(a) - 32'd1),
				.y     (iy_s1 + 32'(b) - 32'd1),
				.value (lat[a][b])
			);
		end
	end

	ovn_cos_rom u_rom (
		.clk   (clk),
		.en    (en),
		.idx_a (carry_s[8].cix),
		.idx_b (carry_s[11].ciy),
		.w_a   (wx_s9),
		.w_b   (wy_s12)
	);

	assign p12_r = (p12_s10 + P_HALF) >>> FB;
	assign p34_r = (p34_s10 + P_HALF) >>> FB;
	assign p_r   = (p_s13 + P_HALF) >>> FB;
	assign r_r   = (r_s14 + R_HALF) >>> (34 - FB);
	assign active = CNT_W_CMP(carry_s[16].pass.count);

	always_comb begin
		carry_2          = carry_s[1];
		carry_2.amp_next = amp_nxt;
		carry_last       = carry_s[NSTG-1];
		if (active) begin
			carry_last.pass.total = carry_s[NSTG-1].pass.total
				+ ovn_pkg::TOT_W'(contrib_s16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int k = 2; k <= NSTG; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s[1].pass     <= pass_in;
			carry_s[1].amp_next <= pass_in.amp;
			carry_s[1].cix      <= shx[FB-1 -: CTB];
			carry_s[1].ciy      <= shy[FB-1 -: CTB];
			ix_s1       <= shx[FB+31:FB];
			iy_s1       <= shy[FB+31:FB];
			amp_prod_s1 <= AP_W'(pass_in.amp) * AP_W'(persistence);

			carry_s[2] <= carry_2;
			for (int k = 3; k < NSTG; k++) carry_s[k] <= carry_s[k-1];

			// Smoothing: corners, sides and center of each of the four 3x3 windows.
			for (int c = 0; c < 4; c++) begin
				csum_s7[c] <= 34'(lat[c%2][c/2]) + 34'(lat[c%2+2][c/2])
					+ 34'(lat[c%2][c/2+2]) + 34'(lat[c%2+2][c/2+2]);
				ssum_s7[c] <= 34'(lat[c%2][c/2+1]) + 34'(lat[c%2+2][c/2+1])
					+ 34'(lat[c%2+1][c/2]) + 34'(lat[c%2+1][c/2+2]);
				ctr_s7[c]  <= lat[c%2+1][c/2+1];
				sm_s8[c]   <= SM_W'(csum_s7[c]) + (SM_W'(ssum_s7[c]) <<< 1)
					+ (SM_W'(ctr_s7[c]) <<< 2);
			end

			d12_s9  <= D_W'(sm_s8[1]) - D_W'(sm_s8[0]);
			d34_s9  <= D_W'(sm_s8[3]) - D_W'(sm_s8[2]);
			v1_s9   <= sm_s8[0];
			v3_s9   <= sm_s8[2];
			p12_s10 <= P_W'(d12_s9) * P_W'($signed({1'b0, wx_s9}));
			p34_s10 <= P_W'(d34_s9) * P_W'($signed({1'b0, wx_s9}));
			v1_s10  <= v1_s9;
			v3_s10  <= v3_s9;
			a_s11   <= BL_W'(v1_s10) + BL_W'(p12_r);
			b_s11   <= BL_W'(v3_s10) + BL_W'(p34_r);
			d_s12   <= D_W'(b_s11) - D_W'(a_s11);
			a_s12   <= a_s11;
			p_s13   <= P_W'(d_s12) * P_W'($signed({1'b0, wy_s12}));
			a_s13   <= a_s12;
			r_s14   <= a_s13 + BL_W'(p_r);
			ov_s15  <= OV_W'(r_r);
			contrib_s16 <= C_W'(ov_s15) * C_W'($signed({1'b0, carry_s[15].pass.amp}));

			carry_s[NSTG] <= carry_last;
		end
	end

	always_comb begin
		pass_out     = carry_s[NSTG].pass;
		pass_out.amp = carry_s[NSTG].amp_next;
	end
	assign out_vld = vld_s[NSTG];

endmodule

/* rtl/core/octave_value_noise_2d_unit.sv */
// Octave value noise unit: one coordinate pair in, one saturated height out.
// Throughput: one item per cycle; the whole pipeline holds only while the
// last octave cell has a result and the output register is full and not taken.
// Reset clears the pipeline and loads the configuration registers with their
// defaults; there is no clearing pass.
module octave_value_noise_2d_unit #(
	parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ovn_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [ovn_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // coord_x [15:0], coord_y [31:16]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ovn_pkg::OUT_W-1:0]    m_axis_tdata   // height [31:0]
);

	localparam int TW = ovn_pkg::TOT_W;
	localparam logic signed [TW-1:0] H_HALF = TW'(1) <<< (2 * ovn_pkg::FRAC_BITS - 18);
	localparam logic signed [TW-1:0] H_MAX  = TW'(32'sh7fff_ffff);
	localparam logic signed [TW-1:0] H_MIN  = TW'(-33'sd2147483648);

	logic [ovn_pkg::COORD_W-1:0] coord_offset_q;
	logic [ovn_pkg::OCNT_W-1:0]  octave_count_q;
	logic [ovn_pkg::FREQ_W-1:0]  base_frequency_q;
	logic [ovn_pkg::AMP_W-1:0]   base_amplitude_q;
	logic [ovn_pkg::PERS_W-1:0]  persistence_q;

	logic                       en;
	logic                       vld_s1, vld_s2;
	logic [ovn_pkg::X_W-1:0]    x_s1, y_s1;
	ovn_pkg::ovn_pass_t         pass_s2;
	logic [ovn_pkg::CNT_W-1:0]  count_sat;
	logic                       vld_c [0:MAX_OCTAVES];
	ovn_pkg::ovn_pass_t         pass_c [0:MAX_OCTAVES];
	logic                       last_vld;
	logic signed [TW-1:0]       h_full;
	logic [ovn_pkg::OUT_W-1:0]  h_sat;
	logic                       out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_offset_q   <= '0;
			octave_count_q   <= 4'd4;
			base_frequency_q <= 20'd65536;
			base_amplitude_q <= 24'd65536;
			persistence_q    <= 17'd32768;
		end else if (cfg_we) begin
			case (cfg_addr)
				ovn_pkg::REG_COORD_OFFSET:   coord_offset_q   <= cfg_wdata[15:0];
				ovn_pkg::REG_OCTAVE_COUNT:   octave_count_q   <= cfg_wdata[3:0];
				ovn_pkg::REG_BASE_FREQUENCY: base_frequency_q <= cfg_wdata[19:0];
				ovn_pkg::REG_BASE_AMPLITUDE: base_amplitude_q <= cfg_wdata[23:0];
				ovn_pkg::REG_PERSISTENCE:    persistence_q    <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// The chain moves unless its last result cannot enter the output register.
	assign last_vld      = vld_c[MAX_OCTAVES];
	assign en            = !(last_vld && out_vld_q && !m_axis_tready);
	assign s_axis_tready = en;

	assign count_sat = (ovn_pkg::CNT_W'(octave_count_q) > ovn_pkg::CNT_W'(MAX_OCTAVES)) ?
		ovn_pkg::CNT_W'(MAX_OCTAVES) : ovn_pkg::CNT_W'(octave_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= ovn_pkg::X_W'(s_axis_tdata[15:0]) + ovn_pkg::X_W'(coord_offset_q);
			y_s1 <= ovn_pkg::X_W'(s_axis_tdata[31:16]) + ovn_pkg::X_W'(coord_offset_q);
			pass_s2.xb    <= ovn_pkg::XB_W'(x_s1) * ovn_pkg::XB_W'(base_frequency_q);
			pass_s2.yb    <= ovn_pkg::XB_W'(y_s1) * ovn_pkg::XB_W'(base_frequency_q);
			pass_s2.count <= count_sat;
			pass_s2.amp   <= base_amplitude_q;
			pass_s2.total <= '0;
		end
	end

	assign vld_c[0]  = vld_s2;
	assign pass_c[0] = pass_s2;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
		ovn_cell #(
			.OCTAVE (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.in_vld      (vld_c[i]),
			.pass_in     (pass_c[i]),
			.persistence (persistence_q),
			.out_vld     (vld_c[i+1]),
			.pass_out    (pass_c[i+1])
		);
	end

	always_comb begin
		h_full = (pass_c[MAX_OCTAVES].total + H_HALF) >>> (2 * ovn_pkg::FRAC_BITS - 17);
		if (h_full > H_MAX) h_sat = 32'h7fff_ffff;
		else if (h_full < H_MIN) h_sat = 32'h8000_0000;
		else h_sat = h_full[ovn_pkg::OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (last_vld && (!out_vld_q || m_axis_tready)) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_vld && (!out_vld_q || m_axis_tready)) begin
			m_axis_tdata <= h_sat;
		end
	end

	assign m_axis_tvalid = out_vld_q;

	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && last_vld)
		else $error("input stalled without a waiting result");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> last_vld)
		else $error("last cell result lost during a stall");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> pass_s2.count <= ovn_pkg::CNT_W'(MAX_OCTAVES))
		else $error("octave count above the cell chain length");

	a_total_starts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> pass_s2.total == '0)
		else $error("octave sum does not start at zero");

endmodule
